// ===== design/rpti_pkg.sv =====
// shared constants, codes and control types of the range partition tree index
package rpti_pkg;

   localparam int DEF_MAX_LEVELS = 4;
   localparam int DEF_SLOTS_PER_LEVEL = 4096;
   localparam int DEF_MAX_FANOUT = 17;

   localparam int FANOUT_REGS = 4;

   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_PROBE = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_INC   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_TOO_FEW   = 2'd3;

   localparam int KEY_W = 32;
   localparam logic signed [KEY_W-1:0] KEY_MAX_VALUE = 32'sh7fffffff;

   localparam int PART_W = 13;
   localparam logic [PART_W-1:0] PART_MAX = 13'd8191;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVELS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAN0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAN1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAN2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FAN3   = 3'd4;

   localparam logic [2:0] RST_LEVELS = 3'd3;
   localparam logic [4:0] RST_FAN0 = 5'd9;
   localparam logic [4:0] RST_FAN1 = 5'd5;
   localparam logic [4:0] RST_FAN2 = 5'd9;
   localparam logic [4:0] RST_FAN3 = 5'd9;

   typedef struct packed {
      logic                accept;
      logic                clear;
      logic                set_result;
      logic [STATUS_W-1:0] result_status;
      logic                ld_init;
      logic                ld_next;
      logic                ld_commit;
      logic                need_init;
      logic                need_step;
      logic                pr_start;
      logic                lvl_setup;
      logic                bs_read;
      logic                bs_cmp;
      logic                pr_next;
      logic                emit;
   } rpti_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            key_ok;
      logic            ld_avail;
      logic            ld_deeper;
      logic            lvl_zero;
      logic            lvl_last;
      logic            too_few;
      logic            bs_done;
   } rpti_stat_type;

endpackage

// ===== design/rpti_req_if.sv =====
// request channel: operation and key
interface rpti_req_if;
   import rpti_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic signed [KEY_W-1:0] key_value;
   modport source (output valid, output operation, output key_value, input ready);
   modport sink (input valid, input operation, input key_value, output ready);
endinterface

// ===== design/rpti_rsp_if.sv =====
// response channel: partition number and status
interface rpti_rsp_if;
   import rpti_pkg::*;
   logic                valid;
   logic                ready;
   logic [PART_W-1:0]   partition;
   logic [STATUS_W-1:0] status;
   modport source (output valid, output partition, output status, input ready);
   modport sink (input valid, input partition, input status, output ready);
endinterface

// ===== design/rpti_datapath.sv =====
// datapath: config registers, level stores, fill state, search and load arithmetic
module rpti_datapath
   import rpti_pkg::*;
#(
   parameter int MAX_LEVELS = DEF_MAX_LEVELS,
   parameter int SLOTS_PER_LEVEL = DEF_SLOTS_PER_LEVEL,
   parameter int MAX_FANOUT = DEF_MAX_FANOUT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   input  logic [OP_W-1:0]         req_operation,
   input  logic signed [KEY_W-1:0] req_key_value,
   input  rpti_cmd_type            cmd,
   output rpti_stat_type           stat,
   output logic [PART_W-1:0]       rsp_partition,
   output logic [STATUS_W-1:0]     rsp_status
);

   localparam int LEVEL_LIMIT = (MAX_LEVELS < FANOUT_REGS) ? MAX_LEVELS : FANOUT_REGS;
   localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int FILL_W = $clog2(SLOTS_PER_LEVEL + 1);
   localparam int CAP_W = FILL_W;
   localparam int FAN_W = $clog2(MAX_FANOUT + 1);
   localparam int FM_W = $clog2(MAX_FANOUT);
   localparam int K_W = FM_W;
   localparam int ACC_W = $clog2(MAX_FANOUT ** LEVEL_LIMIT + 1);
   localparam int BASE_W = ACC_W + FM_W;
   localparam int IDX_W = BASE_W + 1;
   localparam int NEXT_W = BASE_W + 1;
   localparam int PROD_W = CAP_W + FM_W + 1;
   localparam int MEM_DEPTH = MAX_LEVELS * SLOTS_PER_LEVEL;
   localparam int MEM_AW = $clog2(MEM_DEPTH);
   localparam int KEYS_W = $clog2(MEM_DEPTH + 1);
   localparam int TF_W = (KEYS_W > ACC_W) ? KEYS_W : ACC_W;
   localparam int IC_W = (IDX_W > FILL_W) ? IDX_W : FILL_W;
   localparam int SAT_W = (NEXT_W > PART_W) ? NEXT_W : PART_W;

   // configuration
   logic [2:0]            levels_ff;
   logic [4:0]            fanout_ff [FANOUT_REGS];

   // index state
   logic [FILL_W-1:0]     fill_ff [MAX_LEVELS];
   logic [CAP_W-1:0]      cap_ff [MAX_LEVELS];
   logic signed [KEY_W-1:0] prev_key_ff;
   logic                  prev_valid_ff;
   logic [KEYS_W-1:0]     keys_ff;

   // working registers
   logic [OP_W-1:0]       op_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [LVL_W-1:0]      lvl_ff;
   logic                  deeper_ff;
   logic [ACC_W-1:0]      acc_ff;
   logic [BASE_W-1:0]     base_ff;
   logic [K_W-1:0]        lo_ff;
   logic [K_W-1:0]        hi_ff;
   logic signed [KEY_W-1:0] rd_data_ff;
   logic                  oob_ff;
   logic [PART_W-1:0]     res_part_ff;
   logic [STATUS_W-1:0]   res_status_ff;
   logic [PART_W-1:0]     out_part_ff;
   logic [STATUS_W-1:0]   out_status_ff;

   logic signed [KEY_W-1:0] mem [MEM_DEPTH];

   // effective configuration
   logic [3:0]            n_levels;
   logic [3:0]            last_lvl;
   logic [3:0]            lvl_ext;
   logic [4:0]            fan_raw;
   logic [5:0]            fan6;
   logic [FAN_W-1:0]      fan;
   logic [FM_W-1:0]       fm1;

   always_comb begin
      n_levels = 4'(levels_ff);
      if (n_levels < 4'd1) n_levels = 4'd1;
      if (n_levels > 4'(LEVEL_LIMIT)) n_levels = 4'(LEVEL_LIMIT);
      last_lvl = n_levels - 4'd1;
      lvl_ext = 4'(lvl_ff);
      fan_raw = fanout_ff[0];
      for (int i = 1; i < FANOUT_REGS; i++) begin
         if (lvl_ext == 4'(i)) fan_raw = fanout_ff[i];
      end
      fan6 = 6'(fan_raw);
      if (fan6 < 6'd2) fan6 = 6'd2;
      if (fan6 > 6'(MAX_FANOUT)) fan6 = 6'(MAX_FANOUT);
      fan = FAN_W'(fan6);
      fm1 = FM_W'(fan6 - 6'd1);
   end

   // load placement
   logic [FILL_W-1:0]     fill_cur;
   logic [CAP_W-1:0]      cap_cur;
   logic [PROD_W-1:0]     prod_a;
   logic [PROD_W-1:0]     prod_b;
   logic                  ld_avail;
   logic                  ld_overflow;

   always_comb begin
      fill_cur = fill_ff[lvl_ff];
      cap_cur = cap_ff[lvl_ff];
      prod_a = PROD_W'(cap_cur) * PROD_W'(fm1);
      prod_b = prod_a + PROD_W'(fm1);
      ld_avail = (PROD_W'(fill_cur) < prod_a) &&
                 (fill_cur < FILL_W'(SLOTS_PER_LEVEL));
      ld_overflow = prod_b > PROD_W'(SLOTS_PER_LEVEL);
   end

   // node search
   logic [K_W:0]          mid_sum;
   logic [K_W-1:0]        mid;
   logic [IC_W-1:0]       idx;
   logic                  oob;
   logic signed [KEY_W-1:0] slot;
   logic [NEXT_W-1:0]     acc_next;
   logic [SAT_W-1:0]      acc_sat;
   logic [MEM_AW-1:0]     rd_addr;
   logic [MEM_AW-1:0]     wr_addr;

   always_comb begin
      mid_sum = ((K_W+1)'(lo_ff) + (K_W+1)'(hi_ff)) >> 1;
      mid = K_W'(mid_sum);
      idx = IC_W'(base_ff) + IC_W'(mid);
      oob = idx >= IC_W'(fill_cur);
      slot = oob_ff ? KEY_MAX_VALUE : rd_data_ff;
      acc_next = NEXT_W'(base_ff) + NEXT_W'(acc_ff) + NEXT_W'(lo_ff);
      acc_sat = SAT_W'(acc_next);
      rd_addr = MEM_AW'(lvl_ff) * MEM_AW'(SLOTS_PER_LEVEL) + MEM_AW'(idx);
      wr_addr = MEM_AW'(lvl_ff) * MEM_AW'(SLOTS_PER_LEVEL) + MEM_AW'(fill_cur);
   end

   // level store
   always_ff @(posedge clock) begin
      if (cmd.ld_commit) mem[wr_addr] <= key_ff;
      if (cmd.bs_read) begin
         rd_data_ff <= mem[rd_addr];
         oob_ff <= oob;
      end
   end

   // configuration and index state
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= RST_LEVELS;
         fanout_ff[0] <= RST_FAN0;
         fanout_ff[1] <= RST_FAN1;
         fanout_ff[2] <= RST_FAN2;
         fanout_ff[3] <= RST_FAN3;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LEVELS: levels_ff <= csr_write_data[2:0];
            CSR_FAN0: fanout_ff[0] <= csr_write_data;
            CSR_FAN1: fanout_ff[1] <= csr_write_data;
            CSR_FAN2: fanout_ff[2] <= csr_write_data;
            CSR_FAN3: fanout_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int j = 0; j < MAX_LEVELS; j++) begin
            fill_ff[j] <= '0;
            cap_ff[j] <= CAP_W'(1);
         end
         prev_valid_ff <= 1'b0;
         keys_ff <= '0;
      end else if (cmd.ld_commit) begin
         fill_ff[lvl_ff] <= fill_cur + FILL_W'(1);
         for (int j = 0; j < MAX_LEVELS; j++) begin
            if (4'(j) > lvl_ext && 4'(j) <= last_lvl) cap_ff[j] <= cap_ff[j] + CAP_W'(1);
         end
         prev_valid_ff <= 1'b1;
         keys_ff <= keys_ff + KEYS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_commit) prev_key_ff <= key_ff;
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff <= req_operation;
         key_ff <= req_key_value;
      end
      if (cmd.ld_init) begin
         lvl_ff <= LVL_W'(last_lvl);
         deeper_ff <= 1'b0;
      end
      if (cmd.ld_next) begin
         lvl_ff <= lvl_ff - LVL_W'(1);
         deeper_ff <= deeper_ff | ld_overflow;
      end
      if (cmd.need_init) begin
         lvl_ff <= '0;
         acc_ff <= ACC_W'(1);
      end
      if (cmd.need_step) begin
         acc_ff <= ACC_W'((ACC_W+FAN_W)'(acc_ff) * (ACC_W+FAN_W)'(fan));
         lvl_ff <= lvl_ff + LVL_W'(1);
      end
      if (cmd.pr_start) begin
         lvl_ff <= '0;
         acc_ff <= '0;
      end
      if (cmd.lvl_setup) begin
         base_ff <= BASE_W'(acc_ff) * BASE_W'(fm1);
         lo_ff <= '0;
         hi_ff <= K_W'(fm1);
      end
      if (cmd.bs_cmp) begin
         if (slot < key_ff) lo_ff <= mid + K_W'(1);
         else hi_ff <= mid;
      end
      if (cmd.pr_next) begin
         acc_ff <= ACC_W'(acc_next);
         if (lvl_ext != last_lvl) lvl_ff <= lvl_ff + LVL_W'(1);
         else begin
            res_part_ff <= (acc_sat > SAT_W'(PART_MAX)) ? PART_MAX : PART_W'(acc_sat);
            res_status_ff <= STATUS_OK;
         end
      end
      if (cmd.set_result) begin
         res_part_ff <= '0;
         res_status_ff <= cmd.result_status;
      end
      if (cmd.emit) begin
         out_part_ff <= res_part_ff;
         out_status_ff <= res_status_ff;
      end
   end

   always_comb begin
      stat.op = op_ff;
      stat.key_ok = !prev_valid_ff || (key_ff > prev_key_ff);
      stat.ld_avail = ld_avail;
      stat.ld_deeper = deeper_ff;
      stat.lvl_zero = lvl_ff == '0;
      stat.lvl_last = lvl_ext == last_lvl;
      stat.too_few = TF_W'(keys_ff) < TF_W'(acc_ff);
      stat.bs_done = lo_ff == hi_ff;
   end

   assign rsp_partition = out_part_ff;
   assign rsp_status = out_status_ff;

endmodule

// ===== design/rpti_controller.sv =====
// controller: sequences clear, load placement and the level by level probe
module rpti_controller
   import rpti_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  rpti_stat_type stat,
   output rpti_cmd_type  cmd
);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DISPATCH = 9'b000000010,
      ST_LD_SCAN  = 9'b000000100,
      ST_PR_NEED  = 9'b000001000,
      ST_PR_LVL   = 9'b000010000,
      ST_PR_RD    = 9'b000100000,
      ST_PR_CMP   = 9'b001000000,
      ST_PR_NEXT  = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.op)
               OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  cmd.set_result = 1'b1;
                  cmd.result_status = STATUS_OK;
                  state_in = ST_DONE;
               end
               OP_LOAD: begin
                  if (!stat.key_ok) begin
                     cmd.set_result = 1'b1;
                     cmd.result_status = STATUS_NOT_INC;
                     state_in = ST_DONE;
                  end else begin
                     cmd.ld_init = 1'b1;
                     state_in = ST_LD_SCAN;
                  end
               end
               OP_PROBE: begin
                  cmd.need_init = 1'b1;
                  state_in = ST_PR_NEED;
               end
               default: begin
                  cmd.set_result = 1'b1;
                  cmd.result_status = STATUS_OK;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_LD_SCAN: begin
            // scan from the bottom level up; deeper levels must take one more node
            if (stat.ld_avail) begin
               cmd.set_result = 1'b1;
               if (stat.ld_deeper) cmd.result_status = STATUS_FULL;
               else begin
                  cmd.ld_commit = 1'b1;
                  cmd.result_status = STATUS_OK;
               end
               state_in = ST_DONE;
            end else if (stat.lvl_zero) begin
               cmd.set_result = 1'b1;
               cmd.result_status = STATUS_FULL;
               state_in = ST_DONE;
            end else begin
               cmd.ld_next = 1'b1;
            end
         end
         ST_PR_NEED: begin
            if (!stat.lvl_last) cmd.need_step = 1'b1;
            else if (stat.too_few) begin
               cmd.set_result = 1'b1;
               cmd.result_status = STATUS_TOO_FEW;
               state_in = ST_DONE;
            end else begin
               cmd.pr_start = 1'b1;
               state_in = ST_PR_LVL;
            end
         end
         ST_PR_LVL: begin
            cmd.lvl_setup = 1'b1;
            state_in = ST_PR_RD;
         end
         ST_PR_RD: begin
            if (stat.bs_done) state_in = ST_PR_NEXT;
            else begin
               cmd.bs_read = 1'b1;
               state_in = ST_PR_CMP;
            end
         end
         ST_PR_CMP: begin
            cmd.bs_cmp = 1'b1;
            state_in = ST_PR_RD;
         end
         ST_PR_NEXT: begin
            cmd.pr_next = 1'b1;
            state_in = stat.lvl_last ? ST_DONE : ST_PR_LVL;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (!reset && state_ff == ST_IDLE && req_valid) |=> state_ff == ST_DISPATCH)
      else $error("accepted item did not reach dispatch");
   a_emit_result: assert property (@(posedge clock) disable iff (reset)
      (!reset && state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished result not presented");
   a_read_then_cmp: assert property (@(posedge clock) disable iff (reset)
      (!reset && state_ff == ST_PR_RD && !stat.bs_done) |=> state_ff == ST_PR_CMP)
      else $error("node read not followed by compare");
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      (!reset && state_ff == ST_IDLE && req_valid) |=> !req_ready)
      else $error("ready while an item is in work");
`endif

endmodule

// ===== design/range_partition_tree_index_unit.sv =====
// top level of the range partition tree index
// Each item is one operation. Clear and a rejected load go from dispatch straight to the
// result; an accepted load first scans upward level by level from the bottom to find room.
// A probe first checks the key count level by level, then per level runs a binary search
// over the node, since the single level store port gives one registered read per compare,
// and then hands the result over. The next item is taken once the result is in the output
// register, even while that result waits; the index is ready right after reset.
module range_partition_tree_index_unit
   import rpti_pkg::*;
#(
   parameter int MAX_LEVELS = DEF_MAX_LEVELS,
   parameter int SLOTS_PER_LEVEL = DEF_SLOTS_PER_LEVEL,
   parameter int MAX_FANOUT = DEF_MAX_FANOUT
) (
   input  logic                  clock,
   input  logic                  reset,
   rpti_req_if.sink              req_chan,
   rpti_rsp_if.source            rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   rpti_cmd_type  cmd;
   rpti_stat_type stat;

   rpti_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rpti_datapath #(
      .MAX_LEVELS      (MAX_LEVELS),
      .SLOTS_PER_LEVEL (SLOTS_PER_LEVEL),
      .MAX_FANOUT      (MAX_FANOUT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_operation    (req_chan.operation),
      .req_key_value    (req_chan.key_value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_partition    (rsp_chan.partition),
      .rsp_status       (rsp_chan.status)
   );

endmodule
